### rtl/core/rca_pkg.sv
// shared constants and types for the zone color average block
`default_nettype none
package rca_pkg;

  localparam int unsigned PIX_BITS     = 8;
  localparam int unsigned SUM_BITS     = 32;
  localparam int unsigned COUNT_BITS   = 25;
  localparam int unsigned STEP_BITS    = $clog2(SUM_BITS);
  localparam int unsigned CFG_IDX_BITS = 2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_ZONE_LEFT   = 2'd0,
    CFG_ZONE_TOP    = 2'd1,
    CFG_ZONE_WIDTH  = 2'd2,
    CFG_ZONE_HEIGHT = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CH_BLUE  = 2'd0,
    CH_GREEN = 2'd1,
    CH_RED   = 2'd2
  } channel_e;

endpackage
`default_nettype wire

### rtl/core/rca_accum.sv
// zone hit test and per-channel running sums with pixel count
`default_nettype none
module rca_accum #(
  parameter int unsigned COORD_BITS = 12
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            pix_en_i,
  input  wire logic                            clear_i,
  input  wire logic [rca_pkg::PIX_BITS-1:0]    pixel_blue_i,
  input  wire logic [rca_pkg::PIX_BITS-1:0]    pixel_green_i,
  input  wire logic [rca_pkg::PIX_BITS-1:0]    pixel_red_i,
  input  wire logic [COORD_BITS-1:0]           column_i,
  input  wire logic [COORD_BITS-1:0]           row_i,
  input  wire logic [COORD_BITS-1:0]           zone_left_i,
  input  wire logic [COORD_BITS-1:0]           zone_top_i,
  input  wire logic [COORD_BITS:0]             zone_width_i,
  input  wire logic [COORD_BITS:0]             zone_height_i,
  output logic      [rca_pkg::SUM_BITS-1:0]    blue_sum_o,
  output logic      [rca_pkg::SUM_BITS-1:0]    green_sum_o,
  output logic      [rca_pkg::SUM_BITS-1:0]    red_sum_o,
  output logic      [rca_pkg::COUNT_BITS-1:0]  pixel_count_o
);
  import rca_pkg::*;

  logic [COORD_BITS:0]   col_end;
  logic [COORD_BITS:0]   row_end;
  logic                  hit;
  logic [SUM_BITS-1:0]   blue_sum_q, blue_sum_d;
  logic [SUM_BITS-1:0]   green_sum_q, green_sum_d;
  logic [SUM_BITS-1:0]   red_sum_q, red_sum_d;
  logic [COUNT_BITS-1:0] count_q, count_d;

  // zone end sums left and width in one extra bit; it wraps if left plus width reaches twice the coordinate range
  assign col_end = {1'b0, zone_left_i} + zone_width_i;
  assign row_end = {1'b0, zone_top_i} + zone_height_i;
  assign hit = (column_i >= zone_left_i) && ({1'b0, column_i} < col_end) &&
               (row_i >= zone_top_i) && ({1'b0, row_i} < row_end);

  always_comb begin
    blue_sum_d  = blue_sum_q;
    green_sum_d = green_sum_q;
    red_sum_d   = red_sum_q;
    count_d     = count_q;
    if (clear_i) begin
      blue_sum_d  = '0;
      green_sum_d = '0;
      red_sum_d   = '0;
      count_d     = '0;
    end else if (pix_en_i && hit) begin
      blue_sum_d  = blue_sum_q + SUM_BITS'(pixel_blue_i);
      green_sum_d = green_sum_q + SUM_BITS'(pixel_green_i);
      red_sum_d   = red_sum_q + SUM_BITS'(pixel_red_i);
      count_d     = count_q + COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blue_sum_q  <= '0;
      green_sum_q <= '0;
      red_sum_q   <= '0;
      count_q     <= '0;
    end else begin
      blue_sum_q  <= blue_sum_d;
      green_sum_q <= green_sum_d;
      red_sum_q   <= red_sum_d;
      count_q     <= count_d;
    end
  end

  assign blue_sum_o    = blue_sum_q;
  assign green_sum_o   = green_sum_q;
  assign red_sum_o     = red_sum_q;
  assign pixel_count_o = count_q;

endmodule
`default_nettype wire

### rtl/core/rca_divider.sv
// shared restoring divider, one quotient bit per cycle
`default_nettype none
module rca_divider (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire logic [rca_pkg::SUM_BITS-1:0]    dividend_i,
  input  wire logic [rca_pkg::COUNT_BITS-1:0]  divisor_i,
  output logic                                 done_o,
  output logic      [rca_pkg::SUM_BITS-1:0]    quotient_o
);
  import rca_pkg::*;

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [STEP_BITS-1:0]  step_q, step_d;
  logic [COUNT_BITS-1:0] rem_q, rem_d;
  logic [SUM_BITS-1:0]   quo_q, quo_d;
  logic [COUNT_BITS-1:0] div_q, div_d;
  logic [COUNT_BITS:0]   rem_shift;
  logic [COUNT_BITS:0]   rem_diff;
  logic                  fit;

  // quotient register starts as the dividend and shifts left into the remainder
  assign rem_shift = {rem_q, quo_q[SUM_BITS-1]};
  assign fit       = rem_shift >= {1'b0, div_q};
  assign rem_diff  = rem_shift - {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      div_d  = divisor_i;
    end else if (busy_q) begin
      rem_d  = fit ? rem_diff[COUNT_BITS-1:0] : rem_shift[COUNT_BITS-1:0];
      quo_d  = {quo_q[SUM_BITS-2:0], fit};
      step_d = step_q + STEP_BITS'(1);
      if (step_q == STEP_BITS'(SUM_BITS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
`default_nettype wire

### rtl/core/roi_color_average.sv
// mean color of a rectangular zone: pixels not marked frame end are taken back to back
// frame end: the pixel is taken, then blue, green and red are divided in turn in the shared
// divider (32 quotient bits per channel) and the output is loaded; no new pixel is taken
// meanwhile, and the load waits while the previous result still waits in the output register
// reset (async, active low) clears the zone to empty, the sums, count and all control
`default_nettype none
module roi_color_average #(
  parameter int unsigned COORD_BITS = 12
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [rca_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  wire logic [COORD_BITS:0]                cfg_data_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic [rca_pkg::PIX_BITS-1:0]       pixel_blue_i,
  input  wire logic [rca_pkg::PIX_BITS-1:0]       pixel_green_i,
  input  wire logic [rca_pkg::PIX_BITS-1:0]       pixel_red_i,
  input  wire logic [COORD_BITS-1:0]              column_i,
  input  wire logic [COORD_BITS-1:0]              row_i,
  input  wire logic                               frame_end_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic      [rca_pkg::PIX_BITS-1:0]       average_blue_o,
  output logic      [rca_pkg::PIX_BITS-1:0]       average_green_o,
  output logic      [rca_pkg::PIX_BITS-1:0]       average_red_o
);
  import rca_pkg::*;

  typedef enum logic [3:0] {
    ST_ACCUM     = 4'b0001,
    ST_DIV_START = 4'b0010,
    ST_DIV_WAIT  = 4'b0100,
    ST_OUTPUT    = 4'b1000
  } state_e;

  state_e                state_q, state_d;
  channel_e              ch_q, ch_d;
  logic [COORD_BITS-1:0] zone_left_q, zone_top_q;
  logic [COORD_BITS:0]   zone_width_q, zone_height_q;
  logic [PIX_BITS-1:0]   res_blue_q, res_green_q, res_red_q;
  logic [PIX_BITS-1:0]   out_blue_q, out_green_q, out_red_q;
  logic                  out_valid_q, out_valid_d;
  logic                  in_fire;
  logic                  load_out;
  logic                  clear_sums;
  logic                  div_start;
  logic                  div_done;
  logic [SUM_BITS-1:0]   dividend;
  logic [SUM_BITS-1:0]   quotient;
  logic [PIX_BITS-1:0]   mean_byte;
  logic [SUM_BITS-1:0]   blue_sum, green_sum, red_sum;
  logic [COUNT_BITS-1:0] pixel_count;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_ACCUM);
  assign in_fire     = in_valid_i && in_ready_o;
  assign load_out    = (state_q == ST_OUTPUT) && (!out_valid_q || out_ready_i);
  assign clear_sums  = load_out;
  assign div_start   = (state_q == ST_DIV_START);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone_left_q   <= '0;
      zone_top_q    <= '0;
      zone_width_q  <= '0;
      zone_height_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_ZONE_LEFT:   zone_left_q   <= cfg_data_i[COORD_BITS-1:0];
        CFG_ZONE_TOP:    zone_top_q    <= cfg_data_i[COORD_BITS-1:0];
        CFG_ZONE_WIDTH:  zone_width_q  <= cfg_data_i;
        CFG_ZONE_HEIGHT: zone_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  rca_accum #(
    .COORD_BITS(COORD_BITS)
  ) u_accum (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pix_en_i      (in_fire),
    .clear_i       (clear_sums),
    .pixel_blue_i  (pixel_blue_i),
    .pixel_green_i (pixel_green_i),
    .pixel_red_i   (pixel_red_i),
    .column_i      (column_i),
    .row_i         (row_i),
    .zone_left_i   (zone_left_q),
    .zone_top_i    (zone_top_q),
    .zone_width_i  (zone_width_q),
    .zone_height_i (zone_height_q),
    .blue_sum_o    (blue_sum),
    .green_sum_o   (green_sum),
    .red_sum_o     (red_sum),
    .pixel_count_o (pixel_count)
  );

  always_comb begin
    case (ch_q)
      CH_BLUE:  dividend = blue_sum;
      CH_GREEN: dividend = green_sum;
      CH_RED:   dividend = red_sum;
      default:  dividend = '0;
    endcase
  end

  rca_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (pixel_count),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // empty zone reads as zero
  assign mean_byte = (pixel_count == '0) ? '0 : quotient[PIX_BITS-1:0];

  always_comb begin
    state_d = state_q;
    ch_d    = ch_q;
    case (state_q)
      ST_ACCUM: begin
        if (in_fire && frame_end_i) begin
          state_d = ST_DIV_START;
          ch_d    = CH_BLUE;
        end
      end
      ST_DIV_START: begin
        state_d = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          case (ch_q)
            CH_BLUE: begin
              ch_d    = CH_GREEN;
              state_d = ST_DIV_START;
            end
            CH_GREEN: begin
              ch_d    = CH_RED;
              state_d = ST_DIV_START;
            end
            default: state_d = ST_OUTPUT;
          endcase
        end
      end
      ST_OUTPUT: begin
        if (load_out) state_d = ST_ACCUM;
      end
      default: state_d = ST_ACCUM;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACCUM;
      ch_q    <= CH_BLUE;
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_DIV_WAIT) && div_done) begin
      case (ch_q)
        CH_BLUE:  res_blue_q  <= mean_byte;
        CH_GREEN: res_green_q <= mean_byte;
        default:  res_red_q   <= mean_byte;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_blue_q  <= res_blue_q;
      out_green_q <= res_green_q;
      out_red_q   <= res_red_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign average_blue_o  = out_blue_q;
  assign average_green_o = out_green_q;
  assign average_red_o   = out_red_q;

endmodule
`default_nettype wire
